FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mdcs_pkg.sv
// ----------------------------------------------------------------------------
// mdcs_pkg
// Commands, reset constants and ratio scaling of the multiplexed display scanner.
// ----------------------------------------------------------------------------
package mdcs_pkg;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_DUTY    = 3'd1,
    CMD_PAT_ONE = 3'd2,
    CMD_PAT_TWO = 3'd3,
    CMD_RATIO   = 3'd4
  } cmd_t;

  localparam logic [7:0]  RESET_DUTY    = 8'd100;
  localparam logic [15:0] RESET_PATTERN = 16'h003F;
  localparam logic [7:0]  RATIO_MAX     = 8'd128;
  localparam int          RATIO_SHIFT   = 7;

endpackage

FILE: rtl/multiplexed_display_crossfade_scan.sv
// ----------------------------------------------------------------------------
// multiplexed_display_crossfade_scan
// Digit scanner with PWM dimming and a two-pattern crossfade per digit.
// ----------------------------------------------------------------------------
// The input channel carries commands: a tick advances display time by one
// slot step and yields one result transfer; the write commands set a digit's
// duty, pattern one, pattern two or crossfade ratio and yield nothing.
// Writes to a digit at or above DIGITS, and unknown commands, are dropped.
// The result channel carries the grid index, segment pattern and drive
// enable for each tick. Every slot is SLOT_TICKS ticks long: a blank phase,
// then pattern one, then pattern two. Slot timing is taken from the digit's
// duty and ratio on the first tick of its slot; patterns are read each tick.
// An accepted tick's result is in the result register from the next cycle; one
// command is accepted in every cycle while in_ready is high. The state update and
// the 8x8 duty-by-ratio multiply feed the result register.
// A stalled receiver holds the result register; input stays ready while it
// is empty or being taken, so a stall backs up after one held result.
// Reset restores duty 100, patterns 0x003F, ratio 0 and starts at digit 0.
// ----------------------------------------------------------------------------
module multiplexed_display_crossfade_scan #(
  parameter int DIGITS     = 8,
  parameter int SLOT_TICKS = 130
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_digit_select,
  input  logic [15:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_grid_index,
  output logic [15:0] out_segment_pattern,
  output logic        out_drive_enable
);
  import mdcs_pkg::*;

  localparam int         DIG_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [4:0] DIGITS_C  = 5'(DIGITS);
  localparam logic [7:0] SLOT_C    = 8'(SLOT_TICKS);
  localparam logic [8:0] SLOT_C9   = 9'(SLOT_TICKS);

  logic [7:0]  duty_r    [DIGITS];
  logic [15:0] pat_one_r [DIGITS];
  logic [15:0] pat_two_r [DIGITS];
  logic [7:0]  ratio_r   [DIGITS];
  logic [3:0]  digit_r;
  logic [7:0]  slot_tick_r;
  logic [7:0]  blank_r;
  logic [7:0]  first_r;

  logic        out_valid_r;
  logic [3:0]  grid_r;
  logic [15:0] seg_r;
  logic        drive_r;

  logic              in_xfer;
  logic              is_tick;
  logic              wr_ok;
  logic [DIG_W-1:0]  wr_idx;
  logic [DIG_W-1:0]  cur_idx;
  logic [7:0]        duty_wr;
  logic [7:0]        ratio_wr;
  logic [7:0]        duty_sel;
  logic [15:0]       prod;
  logic [7:0]        second;
  logic [7:0]        blank_new;
  logic [7:0]        first_new;
  logic [7:0]        blank_cur;
  logic [7:0]        first_cur;
  logic [8:0]        phase_end;
  logic              en;
  logic [15:0]       seg;
  logic [8:0]        tick_inc;
  logic [4:0]        digit_inc;
  logic [7:0]        slot_tick_nxt;
  logic [3:0]        digit_nxt;
  logic              out_valid_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign is_tick  = (in_command == CMD_TICK);
  assign wr_ok    = ({1'b0, in_digit_select} < DIGITS_C);
  assign wr_idx   = in_digit_select[DIG_W-1:0];
  assign cur_idx  = digit_r[DIG_W-1:0];

  assign duty_wr  = (in_write_value > 16'(SLOT_C)) ? SLOT_C : in_write_value[7:0];
  assign ratio_wr = (in_write_value > 16'(RATIO_MAX)) ? RATIO_MAX : in_write_value[7:0];

  assign duty_sel  = duty_r[cur_idx];
  assign prod      = 16'(duty_sel) * 16'(ratio_r[cur_idx]);
  assign second    = prod[RATIO_SHIFT +: 8];
  assign blank_new = SLOT_C - duty_sel;
  assign first_new = duty_sel - second;

  assign blank_cur = (slot_tick_r == 8'd0) ? blank_new : blank_r;
  assign first_cur = (slot_tick_r == 8'd0) ? first_new : first_r;
  assign phase_end = {1'b0, blank_cur} + {1'b0, first_cur};

  always_comb begin
    en  = (slot_tick_r >= blank_cur);
    seg = 16'h0000;
    if (en) begin
      if ({1'b0, slot_tick_r} < phase_end) begin
        seg = pat_one_r[cur_idx];
      end else begin
        seg = pat_two_r[cur_idx];
      end
    end
  end

  assign tick_inc  = {1'b0, slot_tick_r} + 9'd1;
  assign digit_inc = {1'b0, digit_r} + 5'd1;

  always_comb begin
    slot_tick_nxt = tick_inc[7:0];
    digit_nxt     = digit_r;
    if (tick_inc >= SLOT_C9) begin
      slot_tick_nxt = 8'd0;
      digit_nxt     = (digit_inc >= DIGITS_C) ? 4'd0 : digit_inc[3:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = is_tick;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) begin
        duty_r[i]    <= RESET_DUTY;
        pat_one_r[i] <= RESET_PATTERN;
        pat_two_r[i] <= RESET_PATTERN;
        ratio_r[i]   <= 8'd0;
      end
      digit_r     <= 4'd0;
      slot_tick_r <= 8'd0;
      blank_r     <= SLOT_C - RESET_DUTY;
      first_r     <= RESET_DUTY;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        if (is_tick) begin
          blank_r     <= blank_cur;
          first_r     <= first_cur;
          slot_tick_r <= slot_tick_nxt;
          digit_r     <= digit_nxt;
        end else if (wr_ok) begin
          case (in_command)
            CMD_DUTY:    duty_r[wr_idx]    <= duty_wr;
            CMD_PAT_ONE: pat_one_r[wr_idx] <= in_write_value;
            CMD_PAT_TWO: pat_two_r[wr_idx] <= in_write_value;
            CMD_RATIO:   ratio_r[wr_idx]   <= ratio_wr;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_tick) begin
      grid_r  <= digit_r;
      seg_r   <= seg;
      drive_r <= en;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_grid_index      = grid_r;
  assign out_segment_pattern = seg_r;
  assign out_drive_enable    = drive_r;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_tick_gives_result, in_xfer && is_tick, out_valid_r, "tick lost its result")
  `ASSERT_NEXT(a_write_no_result, in_xfer && !is_tick, !out_valid_r, "write gave a result")
  `ASSERT_IMPL(a_blank_is_dark, out_valid_r && !drive_r, seg_r == 16'h0000, "blank not dark")
  `ASSERT_IMPL(a_counters_range, 1'b1,
               ({1'b0, slot_tick_r} < SLOT_C9) && ({1'b0, digit_r} < DIGITS_C),
               "slot counter out of range")

endmodule

FILE: tb/multiplexed_display_crossfade_scan_tb.sv
// ----------------------------------------------------------------------------
// multiplexed_display_crossfade_scan_tb
// Drives tick and write commands into the digit scanner and predicts every
// tick result: the digit being scanned, the blank, pattern-one and
// pattern-two phases of its slot, and the patterns read live on each tick.
// Directed writes cover saturation, ignored digits, unknown commands and
// zero-length phases. Random traffic then runs with free flow, sender gaps,
// receiver stalls, both at once, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module multiplexed_display_crossfade_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdcs_pkg::*;

  localparam int NUM_DIGITS     = 8;
  localparam int SLOT_LEN       = 130;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [3:0]  grid;
    logic [15:0] seg;
    logic        en;
  } tick_result_t;

  logic        clk = 1'b1;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = CMD_TICK;
  logic [3:0]  in_digit_select = 4'd0;
  logic [15:0] in_write_value = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_grid_index;
  logic [15:0] out_segment_pattern;
  logic        out_drive_enable;

  logic [7:0]  duty_mem [NUM_DIGITS];
  logic [15:0] pat_one_mem [NUM_DIGITS];
  logic [15:0] pat_two_mem [NUM_DIGITS];
  logic [7:0]  ratio_mem [NUM_DIGITS];
  logic [3:0]  scan_digit;
  logic [7:0]  slot_pos;
  logic [7:0]  blank_len;
  logic [7:0]  first_len;

  tick_result_t tick_results [$];
  tick_result_t front_res;

  int cmds_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  multiplexed_display_crossfade_scan #(
    .DIGITS    (NUM_DIGITS),
    .SLOT_TICKS(SLOT_LEN)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_digit_select    (in_digit_select),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_grid_index     (out_grid_index),
    .out_segment_pattern(out_segment_pattern),
    .out_drive_enable   (out_drive_enable)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void predict_command(input logic [2:0] cmd, input logic [3:0] dig,
                                          input logic [15:0] val);
    tick_result_t res;
    logic [15:0] second;
    int next_pos;
    if (cmd != CMD_TICK) begin
      if (cmd > CMD_RATIO || dig >= NUM_DIGITS) return;
      case (cmd)
        CMD_DUTY:    duty_mem[dig] = (val > SLOT_LEN) ? 8'(SLOT_LEN) : val[7:0];
        CMD_PAT_ONE: pat_one_mem[dig] = val;
        CMD_PAT_TWO: pat_two_mem[dig] = val;
        default:     ratio_mem[dig] = (val > RATIO_MAX) ? RATIO_MAX : val[7:0];
      endcase
      return;
    end
    if (slot_pos == 8'd0) begin
      second = (16'(duty_mem[scan_digit]) * 16'(ratio_mem[scan_digit])) >> RATIO_SHIFT;
      blank_len = 8'(SLOT_LEN) - duty_mem[scan_digit];
      first_len = duty_mem[scan_digit] - second[7:0];
    end
    res.grid = scan_digit;
    res.seg = 16'd0;
    res.en = 1'b0;
    if (slot_pos >= blank_len) begin
      res.en = 1'b1;
      if (int'(slot_pos) < int'(blank_len) + int'(first_len)) res.seg = pat_one_mem[scan_digit];
      else res.seg = pat_two_mem[scan_digit];
    end
    tick_results.push_back(res);
    next_pos = int'(slot_pos) + 1;
    if (next_pos >= SLOT_LEN) begin
      slot_pos = 8'd0;
      scan_digit = (int'(scan_digit) + 1 >= NUM_DIGITS) ? 4'd0 : scan_digit + 4'd1;
    end else begin
      slot_pos = 8'(next_pos);
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (tick_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual grid %0d seg %0h en %0d",
                   $time, out_grid_index, out_segment_pattern, out_drive_enable);
          errors++;
        end else begin
          front_res = tick_results.pop_front();
          check_field("grid_index", 16'(front_res.grid), 16'(out_grid_index));
          check_field("segment_pattern", front_res.seg, out_segment_pattern);
          check_field("drive_enable", 16'(front_res.en), 16'(out_drive_enable));
          results_seen++;
        end
      end
      if (in_valid && in_ready) begin
        predict_command(in_command, in_digit_select, in_write_value);
        cmds_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("multiplexed_display_crossfade_scan test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [3:0] dig,
                              input logic [15:0] val);
    int taken_before;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_digit_select <= dig;
    in_write_value <= val;
    taken_before = cmds_taken;
    do @(negedge clk); while (cmds_taken == taken_before);
  endtask

  task automatic send_random(input int count);
    logic [2:0]  cmd;
    logic [3:0]  dig;
    logic [15:0] val;
    int pick;
    int sel;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      val = 16'($urandom);
      if (pick < 82) begin
        cmd = CMD_TICK;
        dig = 4'($urandom_range(15));
      end else if (pick < 94) begin
        cmd = 3'($urandom_range(CMD_RATIO, CMD_DUTY));
        dig = 4'($urandom_range(NUM_DIGITS - 1));
        sel = $urandom_range(5);
        if (cmd == CMD_PAT_ONE || cmd == CMD_PAT_TWO) begin
          if (sel == 0) val = 16'd0;
          else if (sel == 1) val = 16'hFFFF;
        end else begin
          case (sel)
            0: val = 16'd0;
            1: val = (cmd == CMD_RATIO) ? 16'(RATIO_MAX) : 16'(SLOT_LEN);
            2: val = 16'($urandom);
            default: val = (cmd == CMD_RATIO) ? 16'($urandom_range(RATIO_MAX))
                                              : 16'($urandom_range(SLOT_LEN));
          endcase
        end
      end else if ($urandom_range(1) == 0) begin
        cmd = 3'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
        dig = 4'($urandom_range(15));
      end else begin
        cmd = 3'($urandom_range(CMD_RATIO, CMD_DUTY));
        dig = 4'($urandom_range(15, NUM_DIGITS));
      end
      send_command(cmd, dig, val);
    end
  endtask

  task automatic run_random_phase(input int count, input int sender_pct,
                                  input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    send_random(count);
  endtask

  task automatic test_directed;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_command(CMD_TICK, 4'd0, 16'd0);
    send_command(CMD_DUTY, 4'd1, 16'd0);
    send_command(CMD_DUTY, 4'd2, 16'hFFFF);
    send_command(CMD_DUTY, 4'd3, 16'(SLOT_LEN + 1));
    send_command(CMD_RATIO, 4'd3, 16'hFFFF);
    send_command(CMD_DUTY, 4'd4, 16'(SLOT_LEN));
    send_command(CMD_RATIO, 4'd4, 16'(RATIO_MAX));
    send_command(CMD_RATIO, 4'd5, 16'(RATIO_MAX + 1));
    send_command(CMD_DUTY, 4'd6, 16'd1);
    send_command(CMD_RATIO, 4'd6, 16'd64);
    send_command(CMD_PAT_ONE, 4'd1, 16'hFFFF);
    send_command(CMD_PAT_TWO, 4'd2, 16'd0);
    send_command(CMD_PAT_ONE, 4'd3, 16'hA5A5);
    send_command(CMD_PAT_TWO, 4'd3, 16'h5A5A);
    send_command(CMD_PAT_TWO, 4'd7, 16'hFFFF);
    send_command(CMD_DUTY, 4'(NUM_DIGITS), 16'd50);
    send_command(CMD_PAT_ONE, 4'd15, 16'hFFFF);
    for (int c = CMD_UNKNOWN_LO; c <= CMD_UNKNOWN_HI; c++) begin
      send_command(3'(c), 4'd0, 16'hFFFF);
    end
    send_command(CMD_DUTY, 4'd0, 16'd10);
    send_command(CMD_PAT_ONE, 4'd0, 16'h1234);
    send_command(CMD_TICK, 4'd15, 16'hFFFF);
    send_command(CMD_TICK, 4'd0, 16'd0);
  endtask

  task automatic test_no_idle;
    run_random_phase(300, 0, 0);
  endtask

  task automatic test_sender_gaps;
    run_random_phase(250, 60, 0);
  endtask

  task automatic test_receiver_stalls;
    run_random_phase(250, 0, 60);
  endtask

  task automatic test_both_idle;
    run_random_phase(250, 21, 21);
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    send_random(100);
  endtask

  initial begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      duty_mem[d] = RESET_DUTY;
      pat_one_mem[d] = RESET_PATTERN;
      pat_two_mem[d] = RESET_PATTERN;
      ratio_mem[d] = 8'd0;
    end
    scan_digit = 4'd0;
    slot_pos = 8'd0;
    blank_len = 8'(SLOT_LEN) - RESET_DUTY;
    first_len = RESET_DUTY;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (tick_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d command transfers and %0d checked tick results, with %0d errors,",
             cmds_taken, results_seen, errors);
    $display("over directed writes, free flow, sender gaps, receiver stalls and a long hold-off.");
    if (errors == 0) begin
      $display("multiplexed_display_crossfade_scan test passed");
    end else begin
      $display("multiplexed_display_crossfade_scan test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/mdcs_pkg.sv
rtl/multiplexed_display_crossfade_scan.sv
tb/multiplexed_display_crossfade_scan_tb.sv
